// ===== rtl/drb_pkg.sv =====
// Shared types and constants for the driven resonator bank.
// Depends on nothing; every other file of the block but drb_ram imports it.
`timescale 1ns / 1ps

package drb_pkg;

  // Bank size and derived widths
  localparam int NUM_RESONATORS = 64;
  localparam int IDX_W = (NUM_RESONATORS > 1) ? $clog2(NUM_RESONATORS) : 1;
  localparam int CNT_W = $clog2(NUM_RESONATORS + 1);

  // Field widths
  localparam int SMP_W  = 24;
  localparam int SUM_W  = 30;
  localparam int ACT_W  = 7;
  localparam int CMD_W  = 2;
  localparam int RIDX_W = 6;

  // Packed memory words: {env, y2, y1} and {gain, damping, feedback}
  localparam int WORD_W = 3 * SMP_W;

  // Configuration register map (byte addresses, word aligned)
  localparam int PADDR_W = 3;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_ACTIVE  = 1'b0;
  localparam logic REG_RELEASE = 1'b1;

  localparam logic [ACT_W-1:0] ACTIVE_RST  = 7'd64;
  localparam logic [SMP_W-1:0] RELEASE_RST = 24'd16776000;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROC = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ENV,
    ST_DONE
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;   // latch the accepted transaction
    logic             coef_we;   // coefficient load of the accepted transaction
    logic             clr_we;    // zero one entry of every memory
    logic             issue;     // start one resonator down the pipeline
    logic             env_rd;    // read the addressed envelope
    logic             out_load;  // move the result into the output register
    logic [IDX_W-1:0] addr;      // clear or issue address
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== rtl/drb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module drb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/drb_cfg_regs.sv =====
// APB-style configuration registers: active resonator count and release factor.
// Depends on drb_pkg.
`timescale 1ns / 1ps

module drb_cfg_regs
  import drb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [ACT_W-1:0]   active_o,
  output logic [SMP_W-1:0]   release_o
);

  logic             wr_en;
  logic [ACT_W-1:0] active_q;
  logic [SMP_W-1:0] release_q;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; low address bits are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= ACTIVE_RST;
      release_q <= RELEASE_RST;
    end else if (wr_en) begin
      if (paddr[REG_SEL_BIT] == REG_ACTIVE) begin
        active_q <= pwdata[ACT_W-1:0];
      end else begin
        release_q <= pwdata[SMP_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (paddr[REG_SEL_BIT] == REG_ACTIVE) begin
      prdata = {{(32-ACT_W){1'b0}}, active_q};
    end else begin
      prdata = {{(32-SMP_W){1'b0}}, release_q};
    end
  end

  assign active_o  = active_q;
  assign release_o = release_q;

endmodule

// ===== rtl/drb_ctrl.sv =====
// Controller state machine: memory clearing pass, command sequencing,
// resonator issue counter and result handoff. Depends on drb_pkg.
`timescale 1ns / 1ps

module drb_ctrl
  import drb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic             out_stall_i,
  input  logic [ACT_W-1:0] active_i,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic [CNT_W-1:0] lim_in;
  logic             accept;
  logic             clr_last;
  logic             run_last;
  logic             can_load;

  // Active count saturated to the bank size
  always_comb begin
    if (32'(active_i) > NUM_RESONATORS) begin
      lim_in = CNT_W'(NUM_RESONATORS);
    end else begin
      lim_in = CNT_W'(active_i);
    end
  end

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign clr_last = (cnt_q == CNT_W'(NUM_RESONATORS - 1));
  assign run_last = (cnt_q == lim_q - CNT_W'(1));
  assign can_load = !stat_i.out_full || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(cmd_i))
            CMD_PROC: state_d = (lim_in == '0) ? ST_DONE : ST_RUN;
            CMD_READ: state_d = ST_ENV;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_RUN: begin
        if (run_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) state_d = ST_DONE;
      end
      ST_ENV: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counter and limit
  always_comb begin
    cnt_d = cnt_q;
    lim_d = lim_q;
    if (accept) begin
      cnt_d = '0;
      lim_d = lim_in;
    end else if (state_q == ST_CLEAR || state_q == ST_RUN) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.addr     = cnt_q[IDX_W-1:0];
    cmd_o.capture  = accept;
    cmd_o.coef_we  = accept && (cmd_e'(cmd_i) == CMD_LOAD);
    case (state_q)
      ST_CLEAR: cmd_o.clr_we   = 1'b1;
      ST_RUN:   cmd_o.issue    = 1'b1;
      ST_ENV:   cmd_o.env_rd   = 1'b1;
      ST_DONE:  cmd_o.out_load = can_load;
      default:  ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      lim_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lim_q   <= lim_d;
    end
  end

endmodule

// ===== rtl/drb_datapath.sv =====
// Resonator datapath: state and coefficient memories, multiply stage,
// round/saturate/envelope stage, sum accumulator and output register.
// Depends on drb_pkg and drb_ram.
`timescale 1ns / 1ps

module drb_datapath
  import drb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic [CMD_W-1:0]         cmd_in_i,
  input  logic signed [SMP_W-1:0]  sample_in_i,
  input  logic [RIDX_W-1:0]        res_index_i,
  input  logic signed [SMP_W-1:0]  feedback_coeff_i,
  input  logic [SMP_W-1:0]         damping_coeff_i,
  input  logic signed [SMP_W-1:0]  drive_gain_i,
  input  logic [SMP_W-1:0]         release_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [SUM_W-1:0]  sum_out_o,
  output logic [SMP_W-1:0]         envelope_out_o
);

  localparam logic signed [47:0] RND22 = 48'sd2097152;
  localparam logic signed [48:0] RND24 = 49'sd8388608;
  localparam logic [47:0]        RNDU24 = 48'd8388608;
  localparam logic signed [27:0] Y_MAX = 28'sd8388607;
  localparam logic signed [27:0] Y_MIN = -28'sd8388608;
  localparam logic signed [SUM_W:0] S_MAX = (SUM_W+1)'(2**(SUM_W-1) - 1);
  localparam logic signed [SUM_W:0] S_MIN = -(SUM_W+1)'(2**(SUM_W-1));

  // Transaction context
  logic signed [SMP_W-1:0] x_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    idx_ok_q;
  cmd_e                    cmd_q;
  logic                    idx_ok_in;

  assign idx_ok_in = (32'(res_index_i) < NUM_RESONATORS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q      <= sample_in_i;
      idx_q    <= IDX_W'(res_index_i);
      idx_ok_q <= idx_ok_in;
      cmd_q    <= cmd_e'(cmd_in_i);
    end
  end

  // Memory ports
  logic              st_we, cf_we, rd_en;
  logic [IDX_W-1:0]  st_waddr, cf_waddr, raddr;
  logic [WORD_W-1:0] st_wdata, cf_wdata, st_rdata, cf_rdata;

  // Stage registers
  logic                    s1_vld_q, s2_vld_q, s3_vld_q;
  logic [IDX_W-1:0]        s1_idx_q, s2_idx_q;
  logic signed [SMP_W-1:0] s2_y1_q;
  logic signed [47:0]      s2_pfb_q, s2_pgn_q;
  logic signed [48:0]      s2_pdm_q;
  logic [47:0]             s2_penv_q;
  logic signed [SMP_W-1:0] s3_y_q;
  logic signed [SUM_W-1:0] sum_q;

  assign rd_en = cmd_i.issue || cmd_i.env_rd;
  assign raddr = cmd_i.issue ? cmd_i.addr : idx_q;

  // Stage 2 results
  logic signed [47:0]      fb_r, gn_r;
  logic signed [48:0]      dm_r;
  logic [47:0]             env_r;
  logic signed [27:0]      y_full;
  logic signed [SMP_W-1:0] y_sat;
  logic [SMP_W:0]          y_neg;
  logic [SMP_W-1:0]        mag, dec, env_new;

  always_comb begin
    fb_r   = s2_pfb_q + RND22;
    gn_r   = s2_pgn_q + RND22;
    dm_r   = s2_pdm_q + RND24;
    env_r  = s2_penv_q + RNDU24;
    y_full = 28'($signed(fb_r[47:22])) - 28'($signed(dm_r[48:24]))
           + 28'($signed(gn_r[47:22]));
    if (y_full > Y_MAX) begin
      y_sat = SMP_W'(Y_MAX);
    end else if (y_full < Y_MIN) begin
      y_sat = SMP_W'(Y_MIN);
    end else begin
      y_sat = y_full[SMP_W-1:0];
    end
    y_neg = -{y_sat[SMP_W-1], y_sat};
    mag   = y_sat[SMP_W-1] ? y_neg[SMP_W-1:0] : y_sat;
    dec   = env_r[47:24];
    env_new = (mag > dec) ? mag : dec;
  end

  // Write-port muxes: clearing pass wins, otherwise writeback or load
  always_comb begin
    if (cmd_i.clr_we) begin
      st_we    = 1'b1;
      st_waddr = cmd_i.addr;
      st_wdata = '0;
      cf_we    = 1'b1;
      cf_waddr = cmd_i.addr;
      cf_wdata = '0;
    end else begin
      st_we    = s2_vld_q;
      st_waddr = s2_idx_q;
      st_wdata = {env_new, s2_y1_q, y_sat};
      cf_we    = cmd_i.coef_we && idx_ok_in;
      cf_waddr = IDX_W'(res_index_i);
      cf_wdata = {drive_gain_i, damping_coeff_i, feedback_coeff_i};
    end
  end

  // State memory: {env, y2, y1}
  drb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_RESONATORS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  // Coefficient memory: {gain, damping, feedback}
  drb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_RESONATORS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cf_we),
    .waddr_i (cf_waddr),
    .wdata_i (cf_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (cf_rdata)
  );

  // Stage 1: memory data in, four products out
  logic signed [SMP_W-1:0] rd_y1, rd_y2, rd_fb, rd_gn;
  logic [SMP_W-1:0]        rd_env, rd_dm;

  assign rd_y1  = st_rdata[SMP_W-1:0];
  assign rd_y2  = st_rdata[2*SMP_W-1:SMP_W];
  assign rd_env = st_rdata[3*SMP_W-1:2*SMP_W];
  assign rd_fb  = cf_rdata[SMP_W-1:0];
  assign rd_dm  = cf_rdata[2*SMP_W-1:SMP_W];
  assign rd_gn  = cf_rdata[3*SMP_W-1:2*SMP_W];

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= cmd_i.addr;
    s2_idx_q  <= s1_idx_q;
    s2_y1_q   <= rd_y1;
    s2_pfb_q  <= rd_fb * rd_y1;
    s2_pgn_q  <= rd_gn * x_q;
    s2_pdm_q  <= $signed({1'b0, rd_dm}) * rd_y2;
    s2_penv_q <= rd_env * release_i;
    s3_y_q    <= y_sat;
  end

  // Pipeline valids and sum accumulator
  logic signed [SUM_W:0] sum_ext;

  assign sum_ext = (SUM_W+1)'(sum_q) + (SUM_W+1)'(s3_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      sum_q    <= '0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (cmd_i.capture) begin
        sum_q <= '0;
      end else if (s3_vld_q) begin
        if (sum_ext > S_MAX) begin
          sum_q <= SUM_W'(S_MAX);
        end else if (sum_ext < S_MIN) begin
          sum_q <= SUM_W'(S_MIN);
        end else begin
          sum_q <= sum_ext[SUM_W-1:0];
        end
      end
    end
  end

  // Output register
  logic                    out_valid_q;
  logic signed [SUM_W-1:0] sum_out_q;
  logic [SMP_W-1:0]        env_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sum_out_q <= (cmd_q == CMD_PROC) ? sum_q : '0;
      env_out_q <= (cmd_q == CMD_READ && idx_ok_q) ? rd_env : '0;
    end
  end

  assign stat_o.pipe_busy = s1_vld_q || s2_vld_q || s3_vld_q;
  assign stat_o.out_full  = out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign sum_out_o        = sum_out_q;
  assign envelope_out_o   = env_out_q;

endmodule

// ===== rtl/driven_resonator_bank.sv =====
// Top level of the driven resonator bank: controller, datapath, config registers.
// Depends on drb_pkg, drb_ctrl, drb_datapath, drb_cfg_regs, drb_ram.
//
//   channel   | handshake                      | payload
//   ----------+--------------------------------+-------------------------------------
//   input     | in_valid_i / in_stall_o        | cmd, sample, index, three coefficients
//   output    | out_valid_o / out_stall_i      | sum_out_o, envelope_out_o
//   config    | psel/penable/pwrite/pready     | paddr, pwdata, prdata
//
// A process transaction issues its active resonators after acceptance: one
// resonator enters the multiply pipeline per cycle (one memory read port),
// the three stages drain, and one more step moves the result out.
// A load or read also ends by loading the output register; input stays
// stalled until then, and a full, stalled output register extends that wait.
// After reset a clearing pass zeroes all memories while input is stalled.
// A finished result waits in the output register while the next transaction
// is accepted.
`timescale 1ns / 1ps

module driven_resonator_bank
  import drb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic signed [SMP_W-1:0] sample_in_i,
  input  logic [RIDX_W-1:0]       res_index_i,
  input  logic signed [SMP_W-1:0] feedback_coeff_i,
  input  logic [SMP_W-1:0]        damping_coeff_i,
  input  logic signed [SMP_W-1:0] drive_gain_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SUM_W-1:0] sum_out_o,
  output logic [SMP_W-1:0]        envelope_out_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic [ACT_W-1:0] active;
  logic [SMP_W-1:0] release_fac;

  // Configuration registers
  drb_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .active_o  (active),
    .release_o (release_fac)
  );

  // Sequencer
  drb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_stall_i (out_stall_i),
    .active_i    (active),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // Arithmetic and storage
  drb_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .cmd_in_i         (cmd_i),
    .sample_in_i      (sample_in_i),
    .res_index_i      (res_index_i),
    .feedback_coeff_i (feedback_coeff_i),
    .damping_coeff_i  (damping_coeff_i),
    .drive_gain_i     (drive_gain_i),
    .release_i        (release_fac),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .sum_out_o        (sum_out_o),
    .envelope_out_o   (envelope_out_o)
  );

endmodule
